>>> hw/rtl/slot_pool_free_stack_ready_fifo_assert.svh
// ----------------------------------------------------------------------------
// Slot pool assertion macros
// Concurrent check macros; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_FREE_STACK_READY_FIFO_ASSERT_SVH
`define SLOT_POOL_FREE_STACK_READY_FIFO_ASSERT_SVH

`ifndef SYNTHESIS
`define SPOOL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPOOL_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SPOOL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPOOL_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> hw/rtl/spool_pkg.sv
// ----------------------------------------------------------------------------
// Slot pool package
// Widths, operation and status codes, register indexes and beat types.
// ----------------------------------------------------------------------------
package spool_pkg;

	localparam int MAX_SLOTS    = 8;
	localparam int SLOT_BITS    = 3;
	localparam int CNT_BITS     = SLOT_BITS + 1;
	localparam int LEN_BITS     = 24;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DAT_BITS = 4;

	localparam logic [CNT_BITS-1:0] SLOT_COUNT_RST = CNT_BITS'(MAX_SLOTS);

	localparam logic [1:0] FN_REQUEST   = 2'd0;
	localparam logic [1:0] FN_READY_PSH = 2'd1;
	localparam logic [1:0] FN_READY_POP = 2'd2;
	localparam logic [1:0] FN_FREE_PSH  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_OFF    = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;
	localparam logic [1:0] ST_NONE   = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_COUNT = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_EN    = CFG_IDX_BITS'(1);

	typedef struct packed {
		logic [1:0]           func;
		logic [SLOT_BITS-1:0] slot_index;
		logic [LEN_BITS-1:0]  frame_length;
	} op_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [SLOT_BITS-1:0] out_slot;
		logic [LEN_BITS-1:0]  out_length;
	} res_item_t;

endpackage

>>> hw/rtl/slot_pool_free_stack_ready_fifo.sv
// ----------------------------------------------------------------------------
// Slot pool with free stack and ready FIFO
// Hands out frame slots from a LIFO free stack and queues filled slots with
// their byte lengths in a circular ready FIFO.
// Usage:
//   op channel  (op_valid / op_stall / op): one operation per beat, namely
//     request free slot, ready push, ready pop or free push.
//   res channel (res_valid / res_stall / res): exactly one result beat per
//     operation, in order: status, slot and length.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register 0 is
//     the slot count (1..8, a write refills the free stack and empties the
//     ready FIFO), register 1 the pool enable. Write only while idle.
//   Each op goes through a chain of two synchronous memory reads (slot
//   memory, then length memory) ahead of the update cycle, which registers
//   the result; no new op is taken until the current one has updated.
//   Reset: 8 slots, free stack holds slots 0..7, ready FIFO empty, all
//   lengths zero, pool disabled.
//   A stalled result is held in the output register; the next op is still
//   taken and waits in its update cycle until the register frees.
// ----------------------------------------------------------------------------
`include "slot_pool_free_stack_ready_fifo_assert.svh"

module slot_pool_free_stack_ready_fifo import spool_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    op_valid,
	output logic                    op_stall,
	input  op_item_t                op,
	output logic                    res_valid,
	input  logic                    res_stall,
	output res_item_t               res,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DAT_BITS-1:0] cfg_data
);

	localparam logic [1:0] SQ_IDLE = 2'd0;
	localparam logic [1:0] SQ_READ = 2'd1;
	localparam logic [1:0] SQ_EXEC = 2'd2;

	logic [1:0]           state_q;
	op_item_t             item_q;
	logic [CNT_BITS-1:0]  slot_count_q;
	logic                 pool_enabled_q;
	logic [CNT_BITS-1:0]  fs_ptr_q;
	logic [CNT_BITS-1:0]  ready_count_q;
	logic [SLOT_BITS-1:0] head_q;
	logic [SLOT_BITS-1:0] tail_q;
	logic [MAX_SLOTS-1:0] fs_vld_q;
	logic [MAX_SLOTS-1:0] len_vld_q;
	logic                 res_valid_q;
	res_item_t            res_q;

	// lower half: free stack, upper half: ready FIFO
	logic [SLOT_BITS-1:0] slot_mem [2*MAX_SLOTS];
	logic [LEN_BITS-1:0]  len_mem [MAX_SLOTS];
	logic [SLOT_BITS-1:0] slot_rd_q;
	logic [LEN_BITS-1:0]  len_rd_q;

	logic                 op_acc;
	logic                 cfg_wr;
	logic                 refill;
	logic                 exec_fire;
	logic [CNT_BITS-1:0]  top_m1;
	logic [SLOT_BITS:0]   raddr;
	logic [SLOT_BITS-1:0] fs_val;
	logic                 slot_ok;
	logic [SLOT_BITS-1:0] head_nx;
	logic [SLOT_BITS-1:0] tail_nx;

	logic [1:0]           st_d;
	logic [SLOT_BITS-1:0] oslot_d;
	logic [LEN_BITS-1:0]  olen_d;
	logic [CNT_BITS-1:0]  top_d;
	logic [CNT_BITS-1:0]  cnt_d;
	logic [SLOT_BITS-1:0] head_d;
	logic [SLOT_BITS-1:0] tail_d;
	logic [MAX_SLOTS-1:0] fs_vld_d;
	logic [MAX_SLOTS-1:0] len_vld_d;
	logic                 slot_we;
	logic [SLOT_BITS:0]   slot_wa;
	logic                 len_we;

	assign op_stall  = (state_q != SQ_IDLE);
	assign cfg_ready = (state_q == SQ_IDLE);
	assign op_acc    = op_valid && !op_stall;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign refill    = cfg_wr && (cfg_index == CFG_SLOT_COUNT) && (cfg_data != '0) &&
		(CNT_BITS'(cfg_data) <= CNT_BITS'(MAX_SLOTS));
	assign exec_fire = (state_q == SQ_EXEC) && !(res_valid_q && res_stall);

	assign top_m1  = fs_ptr_q - CNT_BITS'(1);
	assign raddr   = (op.func == FN_READY_POP) ? {1'b1, head_q} :
		{1'b0, top_m1[SLOT_BITS-1:0]};
	assign fs_val  = fs_vld_q[top_m1[SLOT_BITS-1:0]] ? slot_rd_q : top_m1[SLOT_BITS-1:0];
	assign slot_ok = ({1'b0, item_q.slot_index} < slot_count_q);
	assign head_nx = ((CNT_BITS'(head_q) + CNT_BITS'(1)) == slot_count_q) ? '0 :
		head_q + SLOT_BITS'(1);
	assign tail_nx = ((CNT_BITS'(tail_q) + CNT_BITS'(1)) == slot_count_q) ? '0 :
		tail_q + SLOT_BITS'(1);

	always_comb begin
		st_d      = ST_OK;
		oslot_d   = '0;
		olen_d    = '0;
		top_d     = fs_ptr_q;
		cnt_d     = ready_count_q;
		head_d    = head_q;
		tail_d    = tail_q;
		fs_vld_d  = fs_vld_q;
		len_vld_d = len_vld_q;
		slot_we   = 1'b0;
		slot_wa   = {1'b0, fs_ptr_q[SLOT_BITS-1:0]};
		len_we    = 1'b0;
		if (!pool_enabled_q) begin
			st_d = ST_OFF;
		end else begin
			unique case (item_q.func)
				FN_REQUEST: begin
					if (fs_ptr_q == '0) begin
						st_d = ST_NONE;
					end else begin
						top_d              = top_m1;
						oslot_d            = fs_val;
						len_vld_d[fs_val]  = 1'b0;
					end
				end
				FN_READY_PSH: begin
					if (!slot_ok) begin
						st_d = ST_REJECT;
					end else begin
						len_we                        = 1'b1;
						len_vld_d[item_q.slot_index]  = 1'b1;
						if (ready_count_q >= slot_count_q) begin
							st_d = ST_REJECT;
						end else begin
							slot_we = 1'b1;
							slot_wa = {1'b1, tail_q};
							tail_d  = tail_nx;
							cnt_d   = ready_count_q + CNT_BITS'(1);
						end
					end
				end
				FN_READY_POP: begin
					if (ready_count_q == '0) begin
						st_d = ST_NONE;
					end else begin
						oslot_d = slot_rd_q;
						olen_d  = len_vld_q[slot_rd_q] ? len_rd_q : '0;
						head_d  = head_nx;
						cnt_d   = ready_count_q - CNT_BITS'(1);
					end
				end
				FN_FREE_PSH: begin
					if (!slot_ok || (fs_ptr_q >= slot_count_q)) begin
						st_d = ST_REJECT;
					end else begin
						len_vld_d[item_q.slot_index]      = 1'b0;
						fs_vld_d[fs_ptr_q[SLOT_BITS-1:0]] = 1'b1;
						slot_we                           = 1'b1;
						top_d                             = fs_ptr_q + CNT_BITS'(1);
					end
				end
				default: st_d = ST_REJECT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_acc) begin
			slot_rd_q <= slot_mem[raddr];
		end
		if (exec_fire && slot_we) begin
			slot_mem[slot_wa] <= item_q.slot_index;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_READ) begin
			len_rd_q <= len_mem[slot_rd_q];
		end
		if (exec_fire && len_we) begin
			len_mem[item_q.slot_index] <= item_q.frame_length;
		end
	end

	always_ff @(posedge clk) begin
		if (op_acc) begin
			item_q <= op;
		end
		if (exec_fire) begin
			res_q.status     <= st_d;
			res_q.out_slot   <= oslot_d;
			res_q.out_length <= olen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= SQ_IDLE;
			slot_count_q   <= SLOT_COUNT_RST;
			pool_enabled_q <= 1'b0;
			fs_ptr_q       <= SLOT_COUNT_RST;
			ready_count_q  <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			fs_vld_q       <= '0;
			len_vld_q      <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			unique case (state_q)
				SQ_IDLE: if (op_acc) state_q <= SQ_READ;
				SQ_READ: state_q <= SQ_EXEC;
				SQ_EXEC: if (exec_fire) state_q <= SQ_IDLE;
				default: state_q <= SQ_IDLE;
			endcase

			if (exec_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_wr && (cfg_index == CFG_POOL_EN)) begin
				pool_enabled_q <= cfg_data[0];
			end

			priority if (refill) begin
				slot_count_q  <= CNT_BITS'(cfg_data);
				fs_ptr_q      <= CNT_BITS'(cfg_data);
				ready_count_q <= '0;
				head_q        <= '0;
				tail_q        <= '0;
				fs_vld_q      <= '0;
				len_vld_q     <= '0;
			end else if (exec_fire) begin
				fs_ptr_q      <= top_d;
				ready_count_q <= cnt_d;
				head_q        <= head_d;
				tail_q        <= tail_d;
				fs_vld_q      <= fs_vld_d;
				len_vld_q     <= len_vld_d;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SPOOL_NEVER(a_top_bound, clk, arst_n, fs_ptr_q > slot_count_q, "free top above slot count")
	`SPOOL_NEVER(a_cnt_bound, clk, arst_n, ready_count_q > slot_count_q, "ready count above slot count")
	`SPOOL_ASSERT(a_acc_seq, clk, arst_n, op_acc |=> (state_q == SQ_READ), "accept did not start read")
	`SPOOL_ASSERT(a_exec_res, clk, arst_n, exec_fire |=> res_valid, "result beat lost")

endmodule
